>>> src/rshe_pkg.sv
// Shared types, constants and elaboration-time coefficient tables for the harmonic evaluator.
package rshe_pkg;

    localparam int MAX_BAND  = 7;
    localparam int FRAC_BITS = 27;

    localparam int VAL_W  = 36;   // internal signed Q30 value
    localparam int MAG_W  = 35;   // multiplier operand magnitude
    localparam int COEF_W = 31;   // Q28 / Q30 coefficients
    localparam int SH_W   = 6;

    typedef logic signed [VAL_W-1:0] t_val;
    typedef logic [MAG_W-1:0]        t_mag;
    typedef logic [COEF_W-1:0]       t_coef;
    typedef logic [7:0][COEF_W-1:0]  t_crow;
    typedef logic [7:0][7:0][COEF_W-1:0] t_ctab;
    typedef logic [7:0][MAG_W-1:0]   t_rrow;
    typedef logic [7:0][SH_W-1:0]    t_srow;

    typedef struct packed {
        t_mag            a;
        t_mag            b;
        logic            neg;
        logic [SH_W-1:0] sh;
        logic            rnd;
    } t_mul_req;

    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam t_val        ONE_V   = 36'sh0_4000_0000;
    localparam logic [31:0] PI_Q30  = 32'd3373259426;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] rem;
        logic [63:0] b;
        root = '0;
        rem  = v;
        b    = 64'h4000_0000_0000_0000;
        for (int j = 0; j < 32; j++) begin
            if (rem >= root + b) begin
                rem  = rem - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    // floor(sqrt(floor(n/d * 2^(2fb)))), shift-subtract long division
    function automatic logic [63:0] sqrt_ratio(input logic [63:0] n, input logic [63:0] d,
                                               input int fb);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        if (d == 0) return '0;
        for (int j = 63; j >= 0; j--) begin
            r = {r[62:0], n[j]};
            q = {q[62:0], 1'b0};
            if (r >= d) begin
                r    = r - d;
                q[0] = 1'b1;
            end
        end
        for (int j = 0; j < 2 * fb; j++) begin
            r = {r[62:0], 1'b0};
            q = {q[62:0], 1'b0};
            if (r >= d) begin
                r    = r - d;
                q[0] = 1'b1;
            end
        end
        return isqrt64(q);
    endfunction

    // ceil(2^s / d)
    function automatic logic [63:0] recip_ceil(input int s, input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int j = s; j >= 0; j--) begin
            r = {r[62:0], (j == s)};
            q = {q[62:0], 1'b0};
            if (r >= d) begin
                r    = r - d;
                q[0] = 1'b1;
            end
        end
        return q + {63'b0, (r != 0)};
    endfunction

    function automatic t_ctab mk_c1();
        t_ctab       t;
        logic [63:0] v;
        t = '0;
        for (int i = 0; i < 8; i++) begin
            for (int m = 0; m < 8; m++) begin
                if (i >= m + 2) begin
                    v = sqrt_ratio(64'(4 * i * i - 1), 64'(i * i - m * m), 28);
                    t[i][m] = v[COEF_W-1:0];
                end
            end
        end
        return t;
    endfunction

    function automatic t_ctab mk_c2();
        t_ctab       t;
        logic [63:0] v;
        t = '0;
        for (int i = 0; i < 8; i++) begin
            for (int m = 0; m < 8; m++) begin
                if (i >= m + 2) begin
                    v = sqrt_ratio(64'((2 * i + 1) * (i - 1 - m) * (i - 1 + m)),
                                   64'((2 * i - 3) * (i - m) * (i + m)), 28);
                    t[i][m] = v[COEF_W-1:0];
                end
            end
        end
        return t;
    endfunction

    function automatic t_crow mk_diag();
        t_crow       t;
        logic [63:0] v;
        t = '0;
        for (int k = 1; k < 8; k++) begin
            v = sqrt_ratio(64'(2 * k + 1), 64'(2 * k), 30);
            t[k] = v[COEF_W-1:0];
        end
        return t;
    endfunction

    function automatic t_crow mk_sq3();
        t_crow       t;
        logic [63:0] v;
        for (int m = 0; m < 8; m++) begin
            v = sqrt_ratio(64'(2 * m + 3), 64'd1, 28);
            t[m] = v[COEF_W-1:0];
        end
        return t;
    endfunction

    // Taylor divisors: sine (2k)(2k+1), cosine (2k-1)(2k), index k-1
    function automatic int tay_div(input int k, input bit cosine);
        return cosine ? (2 * k - 1) * (2 * k) : (2 * k) * (2 * k + 1);
    endfunction

    function automatic t_srow mk_tsh(input bit cosine);
        t_srow t;
        for (int k = 1; k <= 8; k++)
            t[k-1] = SH_W'(32 + $clog2(tay_div(k, cosine)));
        return t;
    endfunction

    function automatic t_rrow mk_trc(input bit cosine);
        t_rrow       t;
        logic [63:0] v;
        for (int k = 1; k <= 8; k++) begin
            v = recip_ceil(32 + $clog2(tay_div(k, cosine)), 64'(tay_div(k, cosine)));
            t[k-1] = v[MAG_W-1:0];
        end
        return t;
    endfunction

    localparam t_ctab C1_TAB   = mk_c1();
    localparam t_ctab C2_TAB   = mk_c2();
    localparam t_crow DIAG_TAB = mk_diag();
    localparam t_crow SQ3_TAB  = mk_sq3();
    localparam t_srow SIN_SH   = mk_tsh(1'b0);
    localparam t_srow COS_SH   = mk_tsh(1'b1);
    localparam t_rrow SIN_RC   = mk_trc(1'b0);
    localparam t_rrow COS_RC   = mk_trc(1'b1);

    localparam logic [63:0] P00_W   = sqrt_ratio(64'd100000, 64'd1256636, 30);
    localparam logic [63:0] SQRT2_W = sqrt_ratio(64'd2, 64'd1, 30);
    localparam t_coef       P00     = P00_W[COEF_W-1:0];
    localparam t_coef       SQRT2   = SQRT2_W[COEF_W-1:0];

    function automatic t_mag mag_of(input t_val v);
        logic [VAL_W-1:0] a;
        a = v[VAL_W-1] ? -v : v;
        return a[MAG_W-1:0];
    endfunction

endpackage

>>> src/real_spherical_harmonic_eval.sv
// Real spherical harmonic Y(l,m) evaluator: sequencer around one shared multiplier.
//
// One beat in gives band l, order m, azimuth theta and polar phi (16-bit turn fractions);
// one beat out gives Y(l,m) in signed Q(FRAC_BITS) saturated to 32 bits, plus bad_index,
// which is set (value zero) when |m| > l. Everything runs through a single multiplier
// with a registered product, so each multiply spends an issue phase and a write-back
// phase, and the block holds o_stall high until the item is finished. Sine/cosine is
// a Horner Taylor series (8 steps, each step a product and a divide done as a
// reciprocal multiply): 35 multiplies. An item takes 35 + 2|m| + R + T multiplies,
// where R = 2 + 3(l-|m|-1) when l > |m| (else 0) and T = 37 when m != 0 (second
// sine/cosine, sqrt2 and trig factor). An index error skips the multiplies. The
// finished beat sits in an output register, so the next item can be taken while it
// waits. Normalization coefficients are constant tables built at elaboration.
module real_spherical_harmonic_eval #(
    parameter int FRAC_BITS = rshe_pkg::FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_band,
    input  logic signed [3:0] i_order,
    input  logic [15:0] i_azimuth,
    input  logic [15:0] i_polar,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [31:0] o_value,
    output logic        o_bad_index
);
    import rshe_pkg::*;

    localparam int SHR  = (FRAC_BITS <= 30) ? 30 - FRAC_BITS : 0;
    localparam int SHR1 = (SHR > 0) ? SHR - 1 : 0;
    localparam int SHL  = (FRAC_BITS > 30) ? FRAC_BITS - 30 : 0;

    // sequencer states
    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_SCX  = 5'd1;   // x = f * pi
    localparam logic [4:0] ST_SCX2 = 5'd2;   // x^2
    localparam logic [4:0] ST_TS1  = 5'd3;   // x^2 * ts
    localparam logic [4:0] ST_TS2  = 5'd4;   // divide, ts = 1 - q
    localparam logic [4:0] ST_TC1  = 5'd5;
    localparam logic [4:0] ST_TC2  = 5'd6;
    localparam logic [4:0] ST_SCS  = 5'd7;   // s = x * ts, quadrant
    localparam logic [4:0] ST_DG1  = 5'd8;   // diagonal step
    localparam logic [4:0] ST_DG2  = 5'd9;
    localparam logic [4:0] ST_M1A  = 5'd10;  // first off-diagonal
    localparam logic [4:0] ST_M1B  = 5'd11;
    localparam logic [4:0] ST_R1   = 5'd12;  // three-term recurrence
    localparam logic [4:0] ST_R2   = 5'd13;
    localparam logic [4:0] ST_R3   = 5'd14;
    localparam logic [4:0] ST_SQ2  = 5'd15;  // times sqrt 2
    localparam logic [4:0] ST_TRG  = 5'd16;  // times cos/sin of m*theta
    localparam logic [4:0] ST_FIN  = 5'd17;

    logic [4:0] r_st, n_st;
    logic       r_ph, n_ph;
    logic       r_ovld;

    // item registers
    logic [2:0]  r_l;
    logic [2:0]  r_mm;
    logic        r_neg;
    logic        r_mz;
    logic        r_bad;
    logic        r_pass;     // 0: polar angle, 1: m*azimuth
    logic [15:0] r_po;
    logic [15:0] r_az;

    // sine/cosine working set
    logic [30:0] r_x;
    logic [31:0] r_x2;
    logic [31:0] r_t;
    logic [30:0] r_ts;
    logic [30:0] r_tc;
    logic [2:0]  r_k;

    // recurrence working set
    logic [30:0] r_s;
    t_val        r_xc;
    t_val        r_trig;
    t_val        r_cur;
    t_val        r_prev;
    t_val        r_tmp;
    logic [2:0]  r_cnt;
    logic [2:0]  r_i;

    logic signed [31:0] r_oval;
    logic               r_obad;

    t_mul_req mul_req;
    t_val     mul_y;

    logic        in_acc;
    logic        fin_go;
    logic [3:0]  mm_in;
    logic        bad_in;
    logic [18:0] az_full;
    logic [15:0] ang;
    logic [1:0]  quad;
    logic [30:0] sc_s;
    t_val        sn;
    t_val        cs;
    logic [30:0] tay;
    logic [4:0]  post_st;
    logic [4:0]  after_p;

    logic [35:0]        cv_a;
    logic [63:0]        cv_m;
    logic [63:0]        cv_r;
    logic signed [31:0] cv_out;

    rshe_mul u_mul (
        .i_clk (i_clk),
        .i_req (mul_req),
        .o_y   (mul_y)
    );

    assign o_stall     = (r_st != ST_IDLE);
    assign o_valid     = r_ovld;
    assign o_value     = r_oval;
    assign o_bad_index = r_obad;

    assign in_acc  = i_valid && (r_st == ST_IDLE);
    assign fin_go  = (r_st == ST_FIN) && (!r_ovld || !i_stall);
    assign mm_in   = i_order[3] ? -i_order : i_order;
    assign bad_in  = (mm_in > {1'b0, i_band}) || ({1'b0, i_band} > 4'(MAX_BAND));
    assign az_full = {16'b0, mm_in[2:0]} * {3'b0, i_azimuth};
    assign ang     = r_pass ? r_az : r_po;
    assign quad    = ang[15:14];

    // s clamps at one; cosine term never exceeds one
    assign sc_s = (mul_y > ONE_V) ? ONE_Q30 : mul_y[30:0];
    always_comb begin
        case (quad)
            2'd0: begin sn = t_val'({5'b0, sc_s}); cs = t_val'({5'b0, r_tc}); end
            2'd1: begin sn = t_val'({5'b0, r_tc}); cs = -t_val'({5'b0, sc_s}); end
            2'd2: begin sn = -t_val'({5'b0, sc_s}); cs = -t_val'({5'b0, r_tc}); end
            default: begin sn = -t_val'({5'b0, r_tc}); cs = t_val'({5'b0, sc_s}); end
        endcase
    end

    // Horner term: 1 - quotient, floored at zero
    assign tay = (mul_y > ONE_V) ? 31'd0 : (ONE_Q30 - mul_y[30:0]);

    // where to go once P(l,|m|) is done, and once the diagonal is done
    assign post_st = r_mz ? ST_FIN : ST_SCX;
    assign after_p = (r_l > r_mm) ? ST_M1A : post_st;

    // operand selection for the shared multiplier
    always_comb begin
        mul_req     = '0;
        mul_req.sh  = SH_W'(30);
        mul_req.rnd = 1'b1;
        case (r_st)
            ST_SCX: begin
                mul_req.a  = MAG_W'(ang[13:0]);
                mul_req.b  = MAG_W'(PI_Q30);
                mul_req.sh = SH_W'(15);
            end
            ST_SCX2: begin
                mul_req.a = MAG_W'(r_x);
                mul_req.b = MAG_W'(r_x);
            end
            ST_TS1: begin
                mul_req.a = MAG_W'(r_x2);
                mul_req.b = MAG_W'(r_ts);
            end
            ST_TS2: begin
                mul_req.a   = MAG_W'(r_t);
                mul_req.b   = SIN_RC[r_k];
                mul_req.sh  = SIN_SH[r_k];
                mul_req.rnd = 1'b0;
            end
            ST_TC1: begin
                mul_req.a = MAG_W'(r_x2);
                mul_req.b = MAG_W'(r_tc);
            end
            ST_TC2: begin
                mul_req.a   = MAG_W'(r_t);
                mul_req.b   = COS_RC[r_k];
                mul_req.sh  = COS_SH[r_k];
                mul_req.rnd = 1'b0;
            end
            ST_SCS: begin
                mul_req.a = MAG_W'(r_x);
                mul_req.b = MAG_W'(r_ts);
            end
            ST_DG1: begin
                mul_req.a   = MAG_W'(r_s);
                mul_req.b   = mag_of(r_cur);
                mul_req.neg = r_cur[VAL_W-1];
            end
            ST_DG2: begin
                mul_req.a   = mag_of(r_tmp);
                mul_req.b   = MAG_W'(DIAG_TAB[r_cnt]);
                mul_req.neg = r_tmp[VAL_W-1];
            end
            ST_M1A, ST_R1: begin
                mul_req.a   = mag_of(r_xc);
                mul_req.b   = mag_of(r_cur);
                mul_req.neg = r_xc[VAL_W-1] ^ r_cur[VAL_W-1];
            end
            ST_M1B: begin
                mul_req.a   = mag_of(r_tmp);
                mul_req.b   = MAG_W'(SQ3_TAB[r_mm]);
                mul_req.neg = r_tmp[VAL_W-1];
                mul_req.sh  = SH_W'(28);
            end
            ST_R2: begin
                mul_req.a   = mag_of(r_tmp);
                mul_req.b   = MAG_W'(C1_TAB[r_i][r_mm]);
                mul_req.neg = r_tmp[VAL_W-1];
                mul_req.sh  = SH_W'(28);
            end
            ST_R3: begin
                mul_req.a   = mag_of(r_prev);
                mul_req.b   = MAG_W'(C2_TAB[r_i][r_mm]);
                mul_req.neg = r_prev[VAL_W-1];
                mul_req.sh  = SH_W'(28);
            end
            ST_SQ2: begin
                mul_req.a   = mag_of(r_cur);
                mul_req.b   = MAG_W'(SQRT2);
                mul_req.neg = r_cur[VAL_W-1];
            end
            ST_TRG: begin
                mul_req.a   = mag_of(r_cur);
                mul_req.b   = mag_of(r_trig);
                mul_req.neg = r_cur[VAL_W-1] ^ r_trig[VAL_W-1];
            end
            default: ;
        endcase
    end

    // next state; every multiply state spends phase 0 issuing, phase 1 writing back
    always_comb begin
        n_st = r_st;
        n_ph = 1'b0;
        case (r_st)
            ST_IDLE: if (in_acc) begin
                n_st = bad_in ? ST_FIN : ST_SCX;
            end
            ST_FIN: if (fin_go) begin
                n_st = ST_IDLE;
            end
            default: begin
                n_ph = ~r_ph;
                if (r_ph) begin
                    case (r_st)
                        ST_SCX:  n_st = ST_SCX2;
                        ST_SCX2: n_st = ST_TS1;
                        ST_TS1:  n_st = ST_TS2;
                        ST_TS2:  n_st = ST_TC1;
                        ST_TC1:  n_st = ST_TC2;
                        ST_TC2:  n_st = (r_k == 3'd0) ? ST_SCS : ST_TS1;
                        ST_SCS:  n_st = r_pass ? ST_SQ2 :
                                        ((r_mm != 3'd0) ? ST_DG1 : after_p);
                        ST_DG1:  n_st = ST_DG2;
                        ST_DG2:  n_st = (r_cnt == r_mm) ? after_p : ST_DG1;
                        ST_M1A:  n_st = ST_M1B;
                        ST_M1B:  n_st = ({1'b0, r_l} == {1'b0, r_mm} + 4'd1) ? post_st : ST_R1;
                        ST_R1:   n_st = ST_R2;
                        ST_R2:   n_st = ST_R3;
                        ST_R3:   n_st = (r_i == r_l) ? post_st : ST_R1;
                        ST_SQ2:  n_st = ST_TRG;
                        ST_TRG:  n_st = ST_FIN;
                        default: n_st = ST_IDLE;
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_IDLE;
            r_ph   <= 1'b0;
            r_ovld <= 1'b0;
        end else begin
            r_st <= n_st;
            r_ph <= n_ph;
            if (fin_go) begin
                r_ovld <= 1'b1;
            end else if (!i_stall) begin
                r_ovld <= 1'b0;
            end
        end
    end

    function automatic logic [30:0] sc_s_abs(input t_val v);
        t_val a;
        a = -v;
        return a[30:0];
    endfunction

    // write-back of the shared unit's result
    always_ff @(posedge i_clk) begin
        case (r_st)
            ST_IDLE: if (in_acc) begin
                r_l    <= i_band;
                r_mm   <= mm_in[2:0];
                r_neg  <= i_order[3];
                r_mz   <= (i_order == 4'sd0);
                r_bad  <= bad_in;
                r_pass <= 1'b0;
                r_po   <= i_polar;
                r_az   <= az_full[15:0];
                r_cur  <= '0;
            end
            ST_SCX:  if (r_ph) r_x <= mul_y[30:0];
            ST_SCX2: if (r_ph) begin
                r_x2 <= mul_y[31:0];
                r_ts <= ONE_Q30;
                r_tc <= ONE_Q30;
                r_k  <= 3'd7;
            end
            ST_TS1, ST_TC1: if (r_ph) r_t <= mul_y[31:0];
            ST_TS2: if (r_ph) r_ts <= tay;
            ST_TC2: if (r_ph) begin
                r_tc <= tay;
                r_k  <= r_k - 3'd1;
            end
            ST_SCS: if (r_ph) begin
                r_pass <= 1'b1;
                if (!r_pass) begin
                    // |sin phi| and cos phi for the Legendre part
                    r_s   <= sn[VAL_W-1] ? sc_s_abs(sn) : sn[30:0];
                    r_xc  <= cs;
                    r_cur <= t_val'({5'b0, P00});
                    r_cnt <= 3'd1;
                end else begin
                    r_trig <= r_neg ? sn : cs;
                end
            end
            ST_DG1, ST_M1A: if (r_ph) begin
                r_tmp <= mul_y;
                if (r_st == ST_M1A) r_prev <= r_cur;
            end
            ST_DG2: if (r_ph) begin
                r_cur <= -mul_y;
                r_cnt <= r_cnt + 3'd1;
            end
            ST_M1B: if (r_ph) begin
                r_cur <= mul_y;
                r_i   <= r_mm + 3'd2;
            end
            ST_R1, ST_R2: if (r_ph) r_tmp <= mul_y;
            ST_R3: if (r_ph) begin
                r_cur  <= r_tmp - mul_y;
                r_prev <= r_cur;
                r_i    <= r_i + 3'd1;
            end
            ST_SQ2, ST_TRG: if (r_ph) r_cur <= mul_y;
            ST_FIN: if (fin_go) begin
                r_oval <= r_bad ? 32'sd0 : cv_out;
                r_obad <= r_bad;
            end
            default: ;
        endcase
    end

    // Q30 to saturated 32-bit Q(FRAC_BITS), round half away from zero
    always_comb begin
        cv_a = r_cur[VAL_W-1] ? 36'(-r_cur) : 36'(r_cur);
        cv_m = {28'b0, cv_a};
        if (SHR > 0) begin
            cv_r = (cv_m >> SHR) + ((cv_m >> SHR1) & 64'd1);
        end else if (SHL > 0) begin
            cv_r = (cv_m >= (64'd1 << (32 - SHL))) ? (64'd1 << 32) : (cv_m << SHL);
        end else begin
            cv_r = cv_m;
        end
        if (r_cur[VAL_W-1]) begin
            if (cv_r > 64'h8000_0000) cv_r = 64'h8000_0000;
            cv_r   = -cv_r;
            cv_out = cv_r[31:0];
        end else begin
            if (cv_r > 64'h7FFF_FFFF) cv_r = 64'h7FFF_FFFF;
            cv_out = cv_r[31:0];
        end
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("block took an item but did not go busy");

    a_bad_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bad_index) |-> (o_value == 32'sd0))
        else $error("index error beat carries a nonzero value");

    a_taylor_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_TS1) |-> (r_ts <= ONE_Q30 && r_tc <= ONE_Q30))
        else $error("Horner term above one");

    a_rec_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_R1) |-> ({1'b0, r_i} >= {1'b0, r_mm} + 4'd2 && r_i <= r_l))
        else $error("recurrence index out of range");

    a_fin_hands_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_FIN && (!r_ovld || !i_stall)) |=> (o_valid && r_st == ST_IDLE))
        else $error("finished item not moved to output register");

endmodule

>>> src/rshe_mul.sv
// Shared sign-magnitude multiplier with registered product and round/shift post stage.
module rshe_mul (
    input  logic              i_clk,
    input  rshe_pkg::t_mul_req i_req,
    output rshe_pkg::t_val    o_y
);
    import rshe_pkg::*;

    localparam int P_W = 2 * MAG_W;
    localparam logic [P_W-1:0] MAG_MAX = {{(P_W-MAG_W){1'b0}}, {MAG_W{1'b1}}};

    logic [P_W-1:0]  r_p;
    logic            r_neg;
    logic            r_rnd;
    logic [SH_W-1:0] r_sh;

    logic [P_W-1:0]  q1;
    logic [P_W-1:0]  mag;
    t_mag            mag_s;

    always_ff @(posedge i_clk) begin
        r_p   <= {{MAG_W{1'b0}}, i_req.a} * {{MAG_W{1'b0}}, i_req.b};
        r_neg <= i_req.neg;
        r_rnd <= i_req.rnd;
        r_sh  <= i_req.sh;
    end

    // one shifter: shift by sh-1, the dropped-out lsb is the rounding bit
    always_comb begin
        q1    = r_p >> (r_sh - SH_W'(1));
        mag   = {1'b0, q1[P_W-1:1]} + {{(P_W-1){1'b0}}, (r_rnd & q1[0])};
        mag_s = (mag > MAG_MAX) ? MAG_MAX[MAG_W-1:0] : mag[MAG_W-1:0];
        o_y   = r_neg ? -t_val'({1'b0, mag_s}) : t_val'({1'b0, mag_s});
    end

endmodule

>>> bench/tb_real_spherical_harmonic_eval.sv
// Self-checking testbench for the real spherical harmonic evaluator.
`timescale 1ns / 1ps

module tb_real_spherical_harmonic_eval;

    import rshe_pkg::*;

    localparam int NUM_RANDOM = 450;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [2:0]        i_band;
    logic signed [3:0] i_order;
    logic [15:0]       i_azimuth;
    logic [15:0]       i_polar;
    logic              o_valid;
    logic              i_stall;
    logic signed [31:0] o_value;
    logic              o_bad_index;

    real_spherical_harmonic_eval dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_band      (i_band),
        .i_order     (i_order),
        .i_azimuth   (i_azimuth),
        .i_polar     (i_polar),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_value     (o_value),
        .o_bad_index (o_bad_index)
    );

    // One expected output beat.
    typedef struct {
        logic [31:0] value;
        logic        bad;
    } t_harm_result;

    // Directed row: inputs, plus a typed-in result where it is obvious.
    typedef struct {
        logic [2:0]  band;
        logic [3:0]  order;
        logic [15:0] az;
        logic [15:0] po;
        bit          fixed;
        logic [31:0] value;
        logic        bad;
    } t_harm_row;

    t_harm_result pending_harm[$];
    int           mismatch_cnt;
    bit           long_hold;     // request a long receiver hold-off
    bit           quiet_rx;      // receiver never stalls
    bit           quiet_tx;      // sender never idles
    bit           tx_done;       // every item has been sent

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // ---------------------------------------------------------------------
    // Predictor: fixed-point arithmetic at Q30 in 64 bits
    // ---------------------------------------------------------------------
    localparam logic [63:0] Q30_ONE = 64'd1 << 30;
    localparam logic [63:0] PI_30   = 64'd3373259426;
    localparam logic [63:0] CAP_62  = 64'd1 << 62;

    function automatic logic [63:0] root_of(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // sqrt(n/d) in Q(fb), both steps truncating
    function automatic longint root_ratio(input logic [63:0] n, input logic [63:0] d,
                                          input int fb);
        logic [63:0] q;
        logic [63:0] r;
        if (d == 0) return 0;
        q = n / d;
        r = n % d;
        for (int i = 0; i < 2 * fb; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= d) begin
                r = r - d;
                q[0] = 1'b1;
            end
        end
        return longint'(root_of(q));
    endfunction

    function automatic logic [63:0] abs64(input longint a);
        return a < 0 ? 64'(-a) : 64'(a);
    endfunction

    // rounded (half away from zero), magnitude-capped product
    function automatic longint rmul(input longint a, input longint b, input int sh);
        bit          neg;
        logic [63:0] p;
        neg = (a < 0) != (b < 0);
        p = abs64(a) * abs64(b);
        p = (p >> sh) + ((p >> (sh - 1)) & 64'd1);
        if (p > CAP_62) p = CAP_62;
        return neg ? -longint'(p) : longint'(p);
    endfunction

    task automatic turn_sincos(input logic [15:0] a, output longint sn, output longint cs);
        logic [1:0]  quad;
        logic [63:0] f, x, x2, ts, tc, sub, s, c;
        quad = a[15:14];
        f  = 64'(a[13:0]);
        x  = (f * PI_30 + 64'd16384) >> 15;
        x2 = (x * x + (Q30_ONE >> 1)) >> 30;
        ts = Q30_ONE;
        tc = Q30_ONE;
        for (int k = 8; k >= 1; k--) begin
            sub = ((x2 * ts + (Q30_ONE >> 1)) >> 30) / 64'((2 * k) * (2 * k + 1));
            ts  = sub > Q30_ONE ? 0 : Q30_ONE - sub;
            sub = ((x2 * tc + (Q30_ONE >> 1)) >> 30) / 64'((2 * k - 1) * (2 * k));
            tc  = sub > Q30_ONE ? 0 : Q30_ONE - sub;
        end
        s = (x * ts + (Q30_ONE >> 1)) >> 30;
        c = tc;
        if (s > Q30_ONE) s = Q30_ONE;
        if (c > Q30_ONE) c = Q30_ONE;
        case (quad)
            2'd0: begin sn = longint'(s);  cs = longint'(c);  end
            2'd1: begin sn = longint'(c);  cs = -longint'(s); end
            2'd2: begin sn = -longint'(s); cs = -longint'(c); end
            default: begin sn = -longint'(c); cs = longint'(s); end
        endcase
    endtask

    // Q30 to saturated 32-bit output format
    function automatic logic [31:0] q30_to_out(input longint v);
        bit          neg;
        logic [63:0] m;
        int          sh;
        neg = v < 0;
        m = abs64(v);
        if (FRAC_BITS <= 30) begin
            sh = 30 - FRAC_BITS;
            if (sh > 0) m = (m >> sh) + ((m >> (sh - 1)) & 64'd1);
        end else begin
            sh = FRAC_BITS - 30;
            if (m >= (64'd1 << (32 - sh))) m = 64'd1 << 32;
            else m = m << sh;
        end
        if (neg) begin
            if (m > (64'd1 << 31)) m = 64'd1 << 31;
            return 32'(64'd0 - m);
        end
        if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
        return m[31:0];
    endfunction

    task automatic predict_harmonic(input logic [2:0] band, input logic [3:0] order_bits,
                                    input logic [15:0] az, input logic [15:0] po,
                                    output t_harm_result r);
        int     l, m, mm;
        longint sphi, x, s, prev, cur, nxt, ts, tc, y, c1, c2;
        l  = band;
        m  = $signed(order_bits);
        mm = m < 0 ? -m : m;
        if (mm > l || l > MAX_BAND) begin
            r.value = '0;
            r.bad   = 1'b1;
            return;
        end
        turn_sincos(po, sphi, x);
        s = sphi < 0 ? -sphi : sphi;
        cur = root_ratio(100000, 1256636, 30);
        for (int k = 1; k <= mm; k++)
            cur = -rmul(rmul(s, cur, 30), root_ratio(2 * k + 1, 2 * k, 30), 30);
        if (l > mm) begin
            prev = cur;
            cur  = rmul(rmul(x, prev, 30), root_ratio(2 * mm + 3, 1, 28), 28);
            for (int i = mm + 2; i <= l; i++) begin
                c1  = root_ratio(4 * i * i - 1, i * i - mm * mm, 28);
                c2  = root_ratio((2 * i + 1) * (i - 1 - mm) * (i - 1 + mm),
                                 (2 * i - 3) * (i - mm) * (i + mm), 28);
                nxt  = rmul(rmul(x, cur, 30), c1, 28) - rmul(prev, c2, 28);
                prev = cur;
                cur  = nxt;
            end
        end
        y = cur;
        if (m != 0) begin
            turn_sincos(16'(mm * az), ts, tc);
            y = rmul(y, root_ratio(2, 1, 30), 30);
            y = rmul(y, m > 0 ? tc : ts, 30);
        end
        r.value = q30_to_out(y);
        r.bad   = 1'b0;
    endtask

    // ---------------------------------------------------------------------
    // Directed table
    // ---------------------------------------------------------------------
    t_harm_row harm_rows[$];

    function automatic t_harm_row mk_row(input int l, input int m, input int az, input int po,
                                         input bit fixed = 0, input logic [31:0] v = 0,
                                         input logic b = 0);
        t_harm_row t;
        t.band = 3'(l); t.order = 4'(m); t.az = 16'(az); t.po = 16'(po);
        t.fixed = fixed; t.value = v; t.bad = b;
        return t;
    endfunction

    initial begin
        // order beyond band: error flag, zero value
        harm_rows.push_back(mk_row(0, 1, 0, 0, 1, 32'd0, 1'b1));
        harm_rows.push_back(mk_row(0, -1, 16'hFFFF, 16'hFFFF, 1, 32'd0, 1'b1));
        harm_rows.push_back(mk_row(7, -8, 1234, 5000, 1, 32'd0, 1'b1));
        harm_rows.push_back(mk_row(3, 5, 0, 100, 1, 32'd0, 1'b1));
        harm_rows.push_back(mk_row(6, -7, 9999, 32768, 1, 32'd0, 1'b1));
        // l = m = 0 is angle independent; the rest go through the predictor
        harm_rows.push_back(mk_row(0, 0, 0, 0));
        harm_rows.push_back(mk_row(0, 0, 16'hFFFF, 16'hFFFF));
        harm_rows.push_back(mk_row(7, 7, 0, 16384));
        harm_rows.push_back(mk_row(7, -7, 16'hFFFF, 16384));
        harm_rows.push_back(mk_row(7, 0, 0, 0));
        harm_rows.push_back(mk_row(7, 0, 0, 32768));
        harm_rows.push_back(mk_row(1, 1, 16384, 8192));
        harm_rows.push_back(mk_row(1, -1, 16384, 8192));
        harm_rows.push_back(mk_row(4, 2, 8192, 49152));
        harm_rows.push_back(mk_row(5, -3, 40000, 40000));
        harm_rows.push_back(mk_row(7, 1, 32768, 16383));
        harm_rows.push_back(mk_row(6, -6, 65535, 65535));
        harm_rows.push_back(mk_row(2, 1, 12345, 60000));
        harm_rows.push_back(mk_row(7, 4, 21845, 1));
        harm_rows.push_back(mk_row(3, -2, 1, 32767));
    end

    // ---------------------------------------------------------------------
    // Sender
    // ---------------------------------------------------------------------
    task automatic send_beat(input logic [2:0] b, input logic [3:0] o,
                             input logic [15:0] az, input logic [15:0] po);
        t_harm_result r;
        while (!quiet_tx && $urandom_range(99) < 25) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_band    <= b;
        i_order   <= o;
        i_azimuth <= az;
        i_polar   <= po;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_harmonic(b, o, az, po, r);
        pending_harm.push_back(r);
    endtask

    function automatic logic [15:0] pick_angle();
        case ($urandom_range(5))
            0: return 16'($urandom_range(3)) << 14;
            1: return 16'hFFFF - 16'($urandom_range(3));
            2: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int          l, m;
        t_harm_result tr;
        i_valid   = 1'b0;
        i_band    = '0;
        i_order   = '0;
        i_azimuth = '0;
        i_polar   = '0;
        i_rst_n   = 1'b0;
        long_hold = 1'b0;
        quiet_tx  = 1'b0;
        tx_done   = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (harm_rows[j]) begin
            send_beat(harm_rows[j].band, harm_rows[j].order, harm_rows[j].az,
                      harm_rows[j].po);
            if (harm_rows[j].fixed) begin
                tr.value = harm_rows[j].value;
                tr.bad   = harm_rows[j].bad;
                pending_harm[$] = tr;
            end
        end

        for (int n = 0; n < NUM_RANDOM; n++) begin
            // long hold-off while the sender keeps offering fills the output register
            if (n == 60) long_hold = 1'b1;
            // pause until drained once
            if (n == 150) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (pending_harm.size() != 0) @(posedge i_clk);
            end
            quiet_tx = (n >= 220 && n < 300);
            l = $urandom_range(7);
            if ($urandom_range(9) == 0) m = int'($urandom_range(15)) - 8;
            else m = int'($urandom_range(2 * l)) - l;
            send_beat(3'(l), 4'(m), pick_angle(), pick_angle());
        end
        i_valid <= 1'b0;
        quiet_tx = 1'b0;
        tx_done  = 1'b1;
    end

    // ---------------------------------------------------------------------
    // Receiver and checker
    // ---------------------------------------------------------------------
    initial begin
        int hold;
        i_stall  = 1'b0;
        quiet_rx = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                long_hold = 1'b0;
                i_stall <= 1'b1;
                for (hold = 0; hold < 600; hold++) @(posedge i_clk);
            end
            // receiver runs without stalls during the sender's no-idle stretch
            quiet_rx = quiet_tx;
            i_stall <= !quiet_rx && ($urandom_range(99) < 25);
        end
    end

    always @(posedge i_clk) begin
        t_harm_result e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_harm.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected beat: value=%h bad=%b", o_value, o_bad_index);
            end else begin
                e = pending_harm.pop_front();
                if (o_value !== e.value || o_bad_index !== e.bad) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: expected value=%h bad=%b, got value=%h bad=%b",
                                 e.value, e.bad, o_value, o_bad_index);
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // End of run
    // ---------------------------------------------------------------------
    initial begin
        mismatch_cnt = 0;
        @(posedge i_rst_n);
        // wait for the sender to finish and every beat to come back
        wait (tx_done);
        while (pending_harm.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatch_cnt == 0 && pending_harm.size() == 0)
            $display("[real_spherical_harmonic_eval] OK");
        else
            $display("[real_spherical_harmonic_eval] ERROR");
        $finish;
    end

    initial begin
        #(12.0 * 1500000);
        $display("[real_spherical_harmonic_eval] ERROR");
        $finish;
    end

endmodule
